/* sv/pdbc_pkg.sv */
// shared types and constants for the per-destination byte counter
// no dependencies
package pdbc_pkg;

   localparam int V4_ENTRIES = 1024;
   localparam int V6_ENTRIES = 1024;
   localparam int DEEP_ENTRIES = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;
   localparam int V4_IDX_W = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
   localparam int V6_IDX_W = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
   localparam int CNT_W = $clog2(DEEP_ENTRIES + 1);

   localparam logic [13:0] ETH_HDR_BYTES = 14'd14;
   localparam logic [13:0] V4_MIN_BYTES = 14'd34;
   localparam logic [13:0] V6_MIN_BYTES = 14'd54;
   localparam logic [15:0] TYPE_V4 = 16'h0800;
   localparam logic [15:0] TYPE_V6 = 16'h86DD;

   localparam logic [2:0] ST_NOT_IP = 3'd0;
   localparam logic [2:0] ST_TRUNC = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_V4 = 3'd3;
   localparam logic [2:0] ST_V6 = 3'd4;

   typedef struct packed {
      logic [13:0] captured_bytes;
      logic [15:0] ether_type;
      logic [63:0] dest_upper;
      logic [63:0] dest_lower;
      logic [15:0] length_field;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        fresh_entry;
      logic [63:0] running_total;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic set_early;
      logic clear_idx;
      logic rd;
      logic inc_idx;
      logic take_hit;
      logic take_new;
      logic set_full;
      logic do_add;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic scan_end;
      logic full;
      logic hit;
      logic out_free;
   } stat_type;

endpackage

/* sv/per_destination_byte_counter.sv */
// Per-destination IP byte counter. One packet transaction is taken at a time. A frame that is
// not IP or is truncated skips the scan and goes from the check state to the output state. An
// IP frame walks its protocol's table from slot 0 up to the fill count, through a table read
// state and an address compare state per slot: a hit in slot j adds to that slot's total, a miss
// with k entries present appends a new entry at slot k, and a full table (k = 1024) gives a full
// status. The block returns to idle once the result is loaded, then takes the next transaction; a
// stalled result holds the block in its output state until it leaves. Scan time grows with the
// fill count. Tables need no clearing pass after reset: only the fill counts clear.
// depends on pdbc_pkg, pdbc_ctrl, pdbc_dpath
module per_destination_byte_counter import pdbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   pdbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pdbc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/pdbc_ctrl.sv */
// sequencer for the byte counter: accept, classify, scan, update, deliver
// depends on pdbc_pkg
module pdbc_ctrl import pdbc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CHK  = 6'b000010,
      S_RD   = 6'b000100,
      S_CMP  = 6'b001000,
      S_ADD  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.early) begin
               cmd.set_early = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.clear_idx = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (stat.scan_end) begin
               if (stat.full) begin
                  cmd.set_full = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cmd.take_new = 1'b1;
                  state_in = S_ADD;
               end
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in = S_ADD;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in = S_RD;
            end
         end
         S_ADD: begin
            cmd.do_add = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

/* sv/pdbc_dpath.sv */
// datapath: transaction register, address and total tables, adder, result register
// depends on pdbc_pkg
module pdbc_dpath import pdbc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   req_type item_ff;
   logic [CNT_W-1:0] idx_ff, v4_cnt_ff, v6_cnt_ff, slot_ff;
   logic [63:0] old_ff;
   logic [31:0]  v4_rd_addr_ff;
   logic [127:0] v6_rd_addr_ff;
   logic [63:0]  v4_rd_bytes_ff, v6_rd_bytes_ff;
   logic [2:0]  res_status_ff;
   logic        res_fresh_ff;
   logic [63:0] res_total_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [31:0]  v4_addr_mem [V4_ENTRIES];
   logic [63:0]  v4_bytes_mem [V4_ENTRIES];
   logic [127:0] v6_addr_mem [V6_ENTRIES];
   logic [63:0]  v6_bytes_mem [V6_ENTRIES];

   logic is_v6;
   logic [2:0] early_code;
   logic early;
   logic [CNT_W-1:0] cnt_sel;
   logic [63:0] sum;

   assign is_v6 = (item_ff.ether_type == TYPE_V6);

   always_comb begin
      early = 1'b1;
      early_code = ST_NOT_IP;
      if (item_ff.captured_bytes < ETH_HDR_BYTES) begin
         early_code = ST_TRUNC;
      end else if (item_ff.ether_type == TYPE_V4) begin
         if (item_ff.captured_bytes < V4_MIN_BYTES) early_code = ST_TRUNC;
         else early = 1'b0;
      end else if (is_v6) begin
         if (item_ff.captured_bytes < V6_MIN_BYTES) early_code = ST_TRUNC;
         else early = 1'b0;
      end
   end

   assign cnt_sel = is_v6 ? v6_cnt_ff : v4_cnt_ff;
   assign sum = old_ff + {48'd0, item_ff.length_field};

   assign stat.early = early;
   assign stat.scan_end = (idx_ff == cnt_sel);
   assign stat.full = is_v6 ? (v6_cnt_ff == CNT_W'(V6_ENTRIES))
                            : (v4_cnt_ff == CNT_W'(V4_ENTRIES));
   assign stat.hit = is_v6 ? (v6_rd_addr_ff == {item_ff.dest_upper, item_ff.dest_lower})
                           : (v4_rd_addr_ff == item_ff.dest_lower[31:0]);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
      if (cmd.clear_idx) idx_ff <= '0;
      else if (cmd.inc_idx) idx_ff <= idx_ff + 1'b1;
      if (cmd.take_hit) begin
         slot_ff <= idx_ff;
         old_ff <= is_v6 ? v6_rd_bytes_ff : v4_rd_bytes_ff;
         res_fresh_ff <= 1'b0;
      end else if (cmd.take_new) begin
         slot_ff <= idx_ff;
         old_ff <= '0;
         res_fresh_ff <= 1'b1;
      end else if (cmd.set_early || cmd.set_full) begin
         res_fresh_ff <= 1'b0;
      end
      if (cmd.set_early) begin
         res_status_ff <= early_code;
         res_total_ff <= '0;
      end else if (cmd.set_full) begin
         res_status_ff <= ST_FULL;
         res_total_ff <= '0;
      end else if (cmd.do_add) begin
         res_status_ff <= is_v6 ? ST_V6 : ST_V4;
         res_total_ff <= sum;
      end
      if (cmd.load_out) begin
         rsp_ff.status <= res_status_ff;
         rsp_ff.fresh_entry <= res_fresh_ff;
         rsp_ff.running_total <= res_total_ff;
      end
   end

   // tables: registered reads during the scan, writes on insert and update
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         v4_rd_addr_ff <= v4_addr_mem[idx_ff[V4_IDX_W-1:0]];
         v4_rd_bytes_ff <= v4_bytes_mem[idx_ff[V4_IDX_W-1:0]];
         v6_rd_addr_ff <= v6_addr_mem[idx_ff[V6_IDX_W-1:0]];
         v6_rd_bytes_ff <= v6_bytes_mem[idx_ff[V6_IDX_W-1:0]];
      end
      if (cmd.take_new && !is_v6)
         v4_addr_mem[idx_ff[V4_IDX_W-1:0]] <= item_ff.dest_lower[31:0];
      if (cmd.take_new && is_v6)
         v6_addr_mem[idx_ff[V6_IDX_W-1:0]] <= {item_ff.dest_upper, item_ff.dest_lower};
      if (cmd.do_add && !is_v6) v4_bytes_mem[slot_ff[V4_IDX_W-1:0]] <= sum;
      if (cmd.do_add && is_v6) v6_bytes_mem[slot_ff[V6_IDX_W-1:0]] <= sum;
   end

   // entries are only ever appended, so slots below the fill count are the valid ones
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_cnt_ff <= '0;
         v6_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_new && !is_v6) v4_cnt_ff <= v4_cnt_ff + 1'b1;
         if (cmd.take_new && is_v6) v6_cnt_ff <= v6_cnt_ff + 1'b1;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_v4_cnt_range: assert property (@(posedge clock) disable iff (reset)
      v4_cnt_ff <= CNT_W'(V4_ENTRIES)) else $error("v4 fill count overflow");
   a_v6_cnt_range: assert property (@(posedge clock) disable iff (reset)
      v6_cnt_ff <= CNT_W'(V6_ENTRIES)) else $error("v6 fill count overflow");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.take_new && !is_v6 |=> v4_cnt_ff == $past(v4_cnt_ff) + 1'b1)
      else $error("insert did not advance fill count");
   a_uncounted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_V4 && rsp_ff.status != ST_V6
      |-> rsp_ff.running_total == 64'd0 && !rsp_ff.fresh_entry)
      else $error("uncounted transaction carries a total");
`endif

endmodule
